FILE: sv/rbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbl_pkg
// Types, widths and constants shared by the lattice index bounds pipeline.
// ----------------------------------------------------------------------------
package rbl_pkg;

    localparam int COORD_W = 32;          // Q16.16 coordinate
    localparam int ENT_W   = 16;          // Q2.14 matrix entry
    localparam int ROW_W   = 3 * ENT_W;   // packed matrix row
    localparam int PROD_W  = COORD_W + ENT_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int MAG_W   = PROD_W;      // |sum| <= 3 * 2^46
    localparam int RECIP_W = 24;          // Q8.16 reciprocal
    localparam int HALF_W  = MAG_W / 2;
    localparam int PP_W    = HALF_W + RECIP_W;
    localparam int ACC_W   = PP_W + 1;
    localparam int FRAC_SH = 46 - HALF_W; // shift right after the split
    localparam int QMAG_W  = ACC_W - FRAC_SH;
    localparam int IDX_W   = QMAG_W + 1;
    localparam int BND_W   = IDX_W + 1;
    localparam int OUT_W   = 19;
    localparam int CFG_W   = ROW_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ENT_W-1:0]   ent_t;
    typedef logic [ROW_W-1:0]          row_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [RECIP_W-1:0]        recip_t;
    typedef logic [PP_W-1:0]           pp_t;
    typedef logic [ACC_W-1:0]          acc_t;
    typedef logic signed [IDX_W-1:0]   idx_t;
    typedef logic signed [BND_W-1:0]   bnd_t;
    typedef logic signed [OUT_W-1:0]   out_t;

    typedef enum logic [1:0] {
        CFG_ROT_ROW0      = 2'd0,
        CFG_ROT_ROW1      = 2'd1,
        CFG_ROT_ROW2      = 2'd2,
        CFG_LATTICE_RECIP = 2'd3
    } cfg_sel_t;

    localparam row_t   ROW0_RST  = row_t'(48'h0000_0000_4000);
    localparam row_t   ROW1_RST  = row_t'(48'h0000_4000_0000);
    localparam row_t   ROW2_RST  = row_t'(48'h4000_0000_0000);
    localparam recip_t RECIP_RST = recip_t'(24'h01_0000);

    localparam bnd_t BND_MAX = bnd_t'((2 ** (OUT_W - 1)) - 1);
    localparam bnd_t BND_MIN = bnd_t'(-(2 ** (OUT_W - 1)));

    function automatic out_t sat_out(input bnd_t v);
        out_t r;
        if (v > BND_MAX)
        begin
            r = out_t'(BND_MAX);
        end
        else if (v < BND_MIN)
        begin
            r = out_t'(BND_MIN);
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/rotated_box_lattice_index_bounds_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_box_lattice_index_bounds_unit
// Per-axis lattice index bounds of an axis-aligned box rotated into the
// crystal frame, scaled by the reciprocal lattice parameter.
// ----------------------------------------------------------------------------
//  channel   ports                                     handshake
//  input     min_x min_y min_z max_x max_y max_z       start, busy
//  result    lo_i lo_j lo_k hi_i hi_j hi_k             done (one cycle)
//  config    cfg_index cfg_data                        cfg_we
//
//  an item is taken in every cycle; busy stays low
//  result goes through 3 stages of rotate/pick/sum,
//  3 stages of scale, 1 stage of offset and saturation
//  reset clears the valid pipeline and loads the identity matrix, recip 1.0
//  no stalls: the receiver takes each result in its done cycle
// ----------------------------------------------------------------------------
module rotated_box_lattice_index_bounds_unit
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  rbl_pkg::coord_t         min_x,
    input  rbl_pkg::coord_t         min_y,
    input  rbl_pkg::coord_t         min_z,
    input  rbl_pkg::coord_t         max_x,
    input  rbl_pkg::coord_t         max_y,
    input  rbl_pkg::coord_t         max_z,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [rbl_pkg::CFG_W-1:0] cfg_data,
    output logic                    done,
    output rbl_pkg::out_t           lo_i,
    output rbl_pkg::out_t           lo_j,
    output rbl_pkg::out_t           lo_k,
    output rbl_pkg::out_t           hi_i,
    output rbl_pkg::out_t           hi_j,
    output rbl_pkg::out_t           hi_k
);

    rbl_pkg::row_t   row_reg [3];
    rbl_pkg::row_t   row_next [3];
    rbl_pkg::recip_t recip_reg;
    rbl_pkg::recip_t recip_next;
    rbl_pkg::coord_t lo_c [3];
    rbl_pkg::coord_t hi_c [3];
    logic            in_valid;
    logic            ax_valid [3];
    rbl_pkg::sum_t   s_min [3];
    rbl_pkg::sum_t   s_max [3];
    logic            sc_min_valid [3];
    logic            sc_max_valid [3];
    rbl_pkg::idx_t   idx_min [3];
    rbl_pkg::idx_t   idx_max [3];
    rbl_pkg::out_t   lo_reg [3];
    rbl_pkg::out_t   hi_reg [3];
    rbl_pkg::out_t   lo_next [3];
    rbl_pkg::out_t   hi_next [3];
    logic            done_reg;
    logic            done_next;

    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    always_comb
    begin
        row_next   = row_reg;
        recip_next = recip_reg;
        if (cfg_we)
        begin
            unique case (rbl_pkg::cfg_sel_t'(cfg_index))
                rbl_pkg::CFG_ROT_ROW0:      row_next[0] = cfg_data;
                rbl_pkg::CFG_ROT_ROW1:      row_next[1] = cfg_data;
                rbl_pkg::CFG_ROT_ROW2:      row_next[2] = cfg_data;
                rbl_pkg::CFG_LATTICE_RECIP: recip_next  = cfg_data[rbl_pkg::RECIP_W-1:0];
                default:                    recip_next  = recip_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= rbl_pkg::ROW0_RST;
            row_reg[1] <= rbl_pkg::ROW1_RST;
            row_reg[2] <= rbl_pkg::ROW2_RST;
            recip_reg  <= rbl_pkg::RECIP_RST;
        end
        else
        begin
            row_reg   <= row_next;
            recip_reg <= recip_next;
        end
    end

    assign lo_c[0] = min_x;
    assign lo_c[1] = min_y;
    assign lo_c[2] = min_z;
    assign hi_c[0] = max_x;
    assign hi_c[1] = max_y;
    assign hi_c[2] = max_z;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        rbl_axis_range u_range
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (in_valid),
            .row       (row_reg[a]),
            .lo_c      (lo_c),
            .hi_c      (hi_c),
            .out_valid (ax_valid[a]),
            .s_min     (s_min[a]),
            .s_max     (s_max[a])
        );

        rbl_scale u_scale_min
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (ax_valid[a]),
            .s         (s_min[a]),
            .recip     (recip_reg),
            .out_valid (sc_min_valid[a]),
            .idx       (idx_min[a])
        );

        rbl_scale u_scale_max
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (ax_valid[a]),
            .s         (s_max[a]),
            .recip     (recip_reg),
            .out_valid (sc_max_valid[a]),
            .idx       (idx_max[a])
        );

        // scaling is monotonic, so the extreme sums give the extreme indices
        assign lo_next[a] = rbl_pkg::sat_out(rbl_pkg::bnd_t'(idx_min[a]) - rbl_pkg::bnd_t'(1));
        assign hi_next[a] = rbl_pkg::sat_out(rbl_pkg::bnd_t'(idx_max[a]) + rbl_pkg::bnd_t'(1));
    end

    // all six lanes run in lockstep
    assign done_next = sc_min_valid[0] && sc_max_valid[0] && sc_min_valid[1]
                    && sc_max_valid[1] && sc_min_valid[2] && sc_max_valid[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign done = done_reg;
    assign lo_i = lo_reg[0];
    assign lo_j = lo_reg[1];
    assign lo_k = lo_reg[2];
    assign hi_i = hi_reg[0];
    assign hi_j = hi_reg[1];
    assign hi_k = hi_reg[2];

endmodule

FILE: sv/rbl_axis_range.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbl_axis_range
// One rotated axis: smallest and largest row-times-corner sum over the eight
// box corners, three register stages (products, per-term pick, sum).
// ----------------------------------------------------------------------------
module rbl_axis_range
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rbl_pkg::row_t       row,
    input  rbl_pkg::coord_t     lo_c [3],
    input  rbl_pkg::coord_t     hi_c [3],
    output logic                out_valid,
    output rbl_pkg::sum_t       s_min,
    output rbl_pkg::sum_t       s_max
);

    // each term of the sum depends on one coordinate only, so the extreme
    // corner is found term by term
    rbl_pkg::prod_t p_lo_reg [3];
    rbl_pkg::prod_t p_hi_reg [3];
    rbl_pkg::prod_t p_lo_next [3];
    rbl_pkg::prod_t p_hi_next [3];
    rbl_pkg::prod_t t_min_reg [3];
    rbl_pkg::prod_t t_max_reg [3];
    rbl_pkg::prod_t t_min_next [3];
    rbl_pkg::prod_t t_max_next [3];
    rbl_pkg::sum_t  s_min_reg;
    rbl_pkg::sum_t  s_max_reg;
    rbl_pkg::sum_t  s_min_next;
    rbl_pkg::sum_t  s_max_next;
    logic [2:0]     vld_reg;
    logic [2:0]     vld_next;

    always_comb
    begin
        rbl_pkg::ent_t e;
        for (int k = 0; k < 3; k++)
        begin
            e = rbl_pkg::ent_t'(row[k*rbl_pkg::ENT_W +: rbl_pkg::ENT_W]);
            p_lo_next[k] = rbl_pkg::prod_t'(e) * rbl_pkg::prod_t'(lo_c[k]);
            p_hi_next[k] = rbl_pkg::prod_t'(e) * rbl_pkg::prod_t'(hi_c[k]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t_min_next[k] = (p_lo_reg[k] < p_hi_reg[k]) ? p_lo_reg[k] : p_hi_reg[k];
            t_max_next[k] = (p_lo_reg[k] < p_hi_reg[k]) ? p_hi_reg[k] : p_lo_reg[k];
        end
    end

    assign s_min_next = rbl_pkg::sum_t'(t_min_reg[0]) + rbl_pkg::sum_t'(t_min_reg[1])
                      + rbl_pkg::sum_t'(t_min_reg[2]);
    assign s_max_next = rbl_pkg::sum_t'(t_max_reg[0]) + rbl_pkg::sum_t'(t_max_reg[1])
                      + rbl_pkg::sum_t'(t_max_reg[2]);

    assign vld_next = {vld_reg[1:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_lo_reg  <= p_lo_next;
        p_hi_reg  <= p_hi_next;
        t_min_reg <= t_min_next;
        t_max_reg <= t_max_next;
        s_min_reg <= s_min_next;
        s_max_reg <= s_max_next;
    end

    assign out_valid = vld_reg[2];
    assign s_min     = s_min_reg;
    assign s_max     = s_max_reg;

endmodule

FILE: sv/rbl_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbl_scale
// Scales a Q.30 sum by the Q8.16 reciprocal and truncates toward zero to a
// lattice index; three stages (sign/magnitude, split multiply, combine).
// ----------------------------------------------------------------------------
module rbl_scale
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rbl_pkg::sum_t     s,
    input  rbl_pkg::recip_t   recip,
    output logic              out_valid,
    output rbl_pkg::idx_t     idx
);

    logic              neg_reg [2];
    logic              neg_next [2];
    rbl_pkg::mag_t     mag_reg;
    rbl_pkg::mag_t     mag_next;
    rbl_pkg::pp_t      ph_reg;
    rbl_pkg::pp_t      pl_reg;
    rbl_pkg::pp_t      ph_next;
    rbl_pkg::pp_t      pl_next;
    rbl_pkg::idx_t     idx_reg;
    rbl_pkg::idx_t     idx_next;
    rbl_pkg::sum_t     s_neg;
    rbl_pkg::acc_t     acc;
    rbl_pkg::idx_t     q;
    logic [2:0]        vld_reg;
    logic [2:0]        vld_next;

    assign s_neg       = -s;
    assign neg_next[0] = s[rbl_pkg::SUM_W-1];
    assign neg_next[1] = neg_reg[0];
    assign mag_next    = neg_next[0] ? s_neg[rbl_pkg::MAG_W-1:0] : s[rbl_pkg::MAG_W-1:0];

    // magnitude split in two halves keeps each multiplier at 24 x 24
    assign ph_next = rbl_pkg::pp_t'(mag_reg[rbl_pkg::MAG_W-1:rbl_pkg::HALF_W])
                   * rbl_pkg::pp_t'(recip);
    assign pl_next = rbl_pkg::pp_t'(mag_reg[rbl_pkg::HALF_W-1:0])
                   * rbl_pkg::pp_t'(recip);

    // floor((ph * 2^24 + pl) / 2^46) = floor((ph + floor(pl / 2^24)) / 2^22)
    assign acc = rbl_pkg::acc_t'(ph_reg)
               + rbl_pkg::acc_t'(pl_reg[rbl_pkg::PP_W-1:rbl_pkg::HALF_W]);
    assign q   = rbl_pkg::idx_t'(acc[rbl_pkg::ACC_W-1:rbl_pkg::FRAC_SH]);
    assign idx_next = neg_reg[1] ? -q : q;

    assign vld_next = {vld_reg[1:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        ph_reg  <= ph_next;
        pl_reg  <= pl_next;
        idx_reg <= idx_next;
    end

    assign out_valid = vld_reg[2];
    assign idx       = idx_reg;

endmodule
